### src/okm_pkg.sv
// okm_pkg: shared constants, command codes and cell control struct for the
// online k-means update block. No dependencies.
package okm_pkg;

  localparam int MAX_CENTERS_DEF = 32;
  localparam int MAX_DIMS_DEF    = 64;
  localparam int COUNT_BITS_DEF  = 20;

  // field widths fixed by the interface
  localparam int COORD_W = 32;
  localparam int DIST_W  = 64;
  localparam int RATE_W  = 17;

  // command codes
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_POINT = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  // configuration register indexes
  localparam logic REG_CLUSTER_COUNT = 1'b0;
  localparam logic REG_DIM_COUNT     = 1'b1;

  // result kinds
  localparam logic KIND_POINT = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // controls broadcast from the sequencer to every cell
  typedef struct packed {
    logic wr;        // write center memory of the targeted cell
    logic clr_cnt;   // clear the targeted cell's hit count with the write
    logic diff_en;   // register |point - center|
    logic sq_en;     // register the square
    logic acc_en;    // add square into the partial distance
    logic clr_dist;  // clear partial distance
    logic inc;       // increment the targeted cell's hit count
  } okm_ctrl_t;

endpackage

### src/okm_ram.sv
// okm_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module okm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  clk,
  we,
  waddr,
  wdata,
  raddr,
  rdata
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  input  logic             clk;
  input  logic             we;
  input  logic [AW-1:0]    waddr;
  input  logic [WIDTH-1:0] wdata;
  input  logic [AW-1:0]    raddr;
  output logic [WIDTH-1:0] rdata;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/okm_cell.sv
// okm_cell: one center: its coordinate memory, partial distance, hit count
// and one link of the minimum-search chain. Depends on okm_pkg, okm_ram.
module okm_cell #(
  parameter int IDX        = 0,
  parameter int MAX_CENTERS = okm_pkg::MAX_CENTERS_DEF,
  parameter int MAX_DIMS    = okm_pkg::MAX_DIMS_DEF,
  parameter int COUNT_BITS  = okm_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  okm_pkg::okm_ctrl_t               ctrl,
  input  logic [((MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1)-1:0]       addr,
  input  logic [((MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1)-1:0] target,
  input  logic [okm_pkg::COORD_W-1:0]      wdata,
  input  logic [okm_pkg::COORD_W-1:0]      pval,
  input  logic [$clog2(MAX_CENTERS+1)-1:0] eff_k,
  input  logic [((MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1)-1:0] chain_in_idx,
  input  logic [okm_pkg::DIST_W-1:0]       chain_in_dist,
  output logic [((MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1)-1:0] chain_out_idx,
  output logic [okm_pkg::DIST_W-1:0]       chain_out_dist,
  output logic [okm_pkg::COORD_W-1:0]      rdata,
  output logic [COUNT_BITS-1:0]            count
);
  localparam int CW = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;

  logic                           sel;
  logic                           active;
  logic signed [okm_pkg::COORD_W:0] diff;
  logic signed [okm_pkg::COORD_W:0] diff_neg;
  logic [okm_pkg::COORD_W-1:0]    mag;
  logic [okm_pkg::DIST_W-1:0]     sq;
  logic [okm_pkg::DIST_W-1:0]     sq_c;
  logic [okm_pkg::DIST_W:0]       sum;
  logic [okm_pkg::DIST_W-1:0]     part_dist;
  logic                           take_own;

  assign sel    = (target == CW'(IDX));
  assign active = (32'(eff_k) > IDX);

  okm_ram #(
    .WIDTH(okm_pkg::COORD_W),
    .DEPTH(MAX_DIMS)
  ) u_mem (
    .clk  (clk),
    .we   (ctrl.wr && sel),
    .waddr(addr),
    .wdata(wdata),
    .raddr(addr),
    .rdata(rdata)
  );

  // squared difference pipeline
  assign diff     = $signed({pval[okm_pkg::COORD_W-1], pval})
                  - $signed({rdata[okm_pkg::COORD_W-1], rdata});
  assign diff_neg = -diff;
  assign sq_c     = okm_pkg::DIST_W'(mag) * okm_pkg::DIST_W'(mag);
  assign sum      = {1'b0, part_dist} + {1'b0, sq};

  always_ff @(posedge clk) begin
    if (ctrl.diff_en) begin
      mag <= diff[okm_pkg::COORD_W] ? diff_neg[okm_pkg::COORD_W-1:0]
                                    : diff[okm_pkg::COORD_W-1:0];
    end
    if (ctrl.sq_en) begin
      sq <= sq_c;
    end
  end

  // saturating partial distance
  always_ff @(posedge clk) begin
    if (rst || ctrl.clr_dist) begin
      part_dist <= '0;
    end else if (ctrl.acc_en) begin
      part_dist <= sum[okm_pkg::DIST_W] ? '1 : sum[okm_pkg::DIST_W-1:0];
    end
  end

  // hit count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.wr && ctrl.clr_cnt && sel) begin
      count <= '0;
    end else if (ctrl.inc && sel && (count != '1)) begin
      count <= count + 1'b1;
    end
  end

  // minimum chain: strict less keeps the lower index on ties
  assign take_own = (IDX == 0) || (active && (part_dist < chain_in_dist));

  always_ff @(posedge clk) begin
    if (take_own) begin
      chain_out_idx  <= CW'(IDX);
      chain_out_dist <= part_dist;
    end else begin
      chain_out_idx  <= chain_in_idx;
      chain_out_dist <= chain_in_dist;
    end
  end

endmodule

### src/okm_rate.sv
// okm_rate: learning rate floor(65536/sqrt(count)) found bit by bit as the
// largest r with r*r*count <= 2^32. Depends on okm_pkg.
module okm_rate #(
  parameter int COUNT_BITS = okm_pkg::COUNT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [COUNT_BITS-1:0]     cnt,
  output logic                      done,
  output logic [okm_pkg::RATE_W-1:0] rate
);
  localparam int SQW = 2 * okm_pkg::RATE_W;
  localparam int PW  = SQW + COUNT_BITS;

  logic                      busy;
  logic                      phase;
  logic [4:0]                bitpos;
  logic [COUNT_BITS-1:0]     cnt_r;
  logic [okm_pkg::RATE_W-1:0] r_try;
  logic [SQW-1:0]            sq;
  logic [PW-1:0]             prod;
  logic [PW-1:0]             limit;

  assign r_try = rate | (okm_pkg::RATE_W'(1) << bitpos);
  assign prod  = PW'(sq) * PW'(cnt_r);
  assign limit = {{(PW-33){1'b0}}, 1'b1, 32'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        phase  <= 1'b0;
        bitpos <= 5'(okm_pkg::RATE_W - 1);
        cnt_r  <= cnt;
        rate   <= '0;
      end else if (busy) begin
        if (!phase) begin
          sq    <= SQW'(r_try) * SQW'(r_try);
          phase <= 1'b1;
        end else begin
          if (prod <= limit) begin
            rate <= r_try;
          end
          phase <= 1'b0;
          if (bitpos == 5'd0) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            bitpos <= bitpos - 1'b1;
          end
        end
      end
    end
  end

endmodule

### src/online_kmeans_update.sv
// Online k-means center update: a row of center cells, a shared rate unit and
// a sequencer. Depends on okm_pkg, okm_cell, okm_rate, okm_ram.
// A final point coordinate runs the distance steps, then a search wave down the
//   cell row, the bit-serial rate search and an update pass over each coordinate.
// One beat at a time: in_stall holds while the sequencer is busy with a beat.
// Reset: hit counts and partial distances clear, cluster_count and dim_count
//   become 1; center memories and point buffer are undefined until written.
module online_kmeans_update #(
  parameter int MAX_CENTERS = okm_pkg::MAX_CENTERS_DEF,
  parameter int MAX_DIMS    = okm_pkg::MAX_DIMS_DEF,
  parameter int COUNT_BITS  = okm_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [6:0]                  cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  cmd,
  input  logic [4:0]                  center_sel,
  input  logic [5:0]                  dim_sel,
  input  logic signed [31:0]          coord_value,
  input  logic                        last_dim,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        result_kind,
  output logic [4:0]                  winner,
  output logic [63:0]                 best_distance,
  output logic [COUNT_BITS-1:0]       hit_count,
  output logic signed [31:0]          read_value
);
  localparam int AW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int CW  = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
  localparam int KW  = $clog2(MAX_CENTERS + 1);
  localparam int NDW = $clog2(MAX_DIMS + 1);
  localparam int CWD = okm_pkg::COORD_W;
  localparam int PRW = CWD + 1 + okm_pkg::RATE_W + 1;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DEC    = 5'd1;
  localparam logic [4:0] S_RD     = 5'd2;
  localparam logic [4:0] S_P1     = 5'd3;
  localparam logic [4:0] S_P2     = 5'd4;
  localparam logic [4:0] S_P3     = 5'd5;
  localparam logic [4:0] S_SRCH   = 5'd6;
  localparam logic [4:0] S_WIN    = 5'd7;
  localparam logic [4:0] S_INC    = 5'd8;
  localparam logic [4:0] S_CNT    = 5'd9;
  localparam logic [4:0] S_RSTART = 5'd10;
  localparam logic [4:0] S_RATE   = 5'd11;
  localparam logic [4:0] S_U0     = 5'd12;
  localparam logic [4:0] S_U1     = 5'd13;
  localparam logic [4:0] S_U2     = 5'd14;
  localparam logic [4:0] S_U3     = 5'd15;
  localparam logic [4:0] S_OUT    = 5'd16;

  logic [4:0]            state;
  logic [5:0]            cluster_count;
  logic [6:0]            dim_count;
  logic [KW-1:0]         eff_k;
  logic [NDW-1:0]        eff_d;

  // latched beat
  logic [1:0]            cmd_r;
  logic [4:0]            csel_r;
  logic [5:0]            dsel_r;
  logic [CWD-1:0]        val_r;
  logic                  last_r;

  logic                  csel_ok;
  logic                  dsel_ok;
  logic                  pt_in;
  logic                  out_free;

  okm_pkg::okm_ctrl_t    ctrl;
  logic [AW-1:0]         addr;
  logic [CW-1:0]         target;
  logic [CWD-1:0]        wdata;
  logic                  pb_we;
  logic [CWD-1:0]        pb_rdata;

  logic [CW-1:0]         ch_idx  [MAX_CENTERS+1];
  logic [63:0]           ch_dist [MAX_CENTERS+1];
  logic [CWD-1:0]        cell_rdata [MAX_CENTERS];
  logic [COUNT_BITS-1:0] cell_count [MAX_CENTERS];

  logic [KW-1:0]         srch_cnt;
  logic [CW-1:0]         win;
  logic [63:0]           bestd;
  logic [COUNT_BITS-1:0] cnt_r;
  logic                  rate_start;
  logic                  rate_done;
  logic [okm_pkg::RATE_W-1:0] rate;
  logic [NDW-1:0]        upd_d;
  logic [CWD-1:0]        cw_r;
  logic signed [CWD:0]   delta_r;
  logic signed [PRW-1:0] prod_r;
  logic [CWD-1:0]        new_coord;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cluster_count <= 6'd1;
      dim_count     <= 7'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        okm_pkg::REG_CLUSTER_COUNT: cluster_count <= cfg_data[5:0];
        okm_pkg::REG_DIM_COUNT:     dim_count     <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp registers into the usable range
  always_comb begin
    if (cluster_count == 6'd0) begin
      eff_k = KW'(1);
    end else if (32'(cluster_count) > MAX_CENTERS) begin
      eff_k = KW'(MAX_CENTERS);
    end else begin
      eff_k = KW'(cluster_count);
    end
    if (dim_count == 7'd0) begin
      eff_d = NDW'(1);
    end else if (32'(dim_count) > MAX_DIMS) begin
      eff_d = NDW'(MAX_DIMS);
    end else begin
      eff_d = NDW'(dim_count);
    end
  end

  assign csel_ok  = (32'(csel_r) < MAX_CENTERS);
  assign dsel_ok  = (32'(dsel_r) < MAX_DIMS);
  assign pt_in    = (32'(dsel_r) < 32'(eff_d));
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  assign new_coord = cw_r + prod_r[CWD+15:16];

  // broadcast controls
  always_comb begin
    ctrl       = '0;
    addr       = AW'(dsel_r);
    target     = CW'(csel_r);
    wdata      = val_r;
    pb_we      = 1'b0;
    rate_start = 1'b0;
    unique case (state)
      S_DEC: begin
        if (cmd_r == okm_pkg::CMD_WRITE && csel_ok && dsel_ok) begin
          ctrl.wr      = 1'b1;
          ctrl.clr_cnt = (dsel_r == 6'd0);
        end
        if (cmd_r == okm_pkg::CMD_POINT && pt_in) begin
          pb_we = 1'b1;
        end
      end
      S_P1: ctrl.diff_en = 1'b1;
      S_P2: ctrl.sq_en   = 1'b1;
      S_P3: ctrl.acc_en  = 1'b1;
      S_INC: begin
        ctrl.inc = 1'b1;
        target   = win;
      end
      S_RSTART: rate_start = 1'b1;
      S_U0, S_U1, S_U2: addr = AW'(upd_d);
      S_U3: begin
        addr    = AW'(upd_d);
        target  = win;
        ctrl.wr = 1'b1;
        wdata   = new_coord;
      end
      S_OUT: ctrl.clr_dist = out_free;
      default: ;
    endcase
  end

  okm_ram #(
    .WIDTH(CWD),
    .DEPTH(MAX_DIMS)
  ) u_pbuf (
    .clk  (clk),
    .we   (pb_we),
    .waddr(addr),
    .wdata(val_r),
    .raddr(addr),
    .rdata(pb_rdata)
  );

  // row of center cells
  assign ch_idx[0]  = '0;
  assign ch_dist[0] = '1;

  for (genvar i = 0; i < MAX_CENTERS; i++) begin : g_cell
    okm_cell #(
      .IDX        (i),
      .MAX_CENTERS(MAX_CENTERS),
      .MAX_DIMS   (MAX_DIMS),
      .COUNT_BITS (COUNT_BITS)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .ctrl          (ctrl),
      .addr          (addr),
      .target        (target),
      .wdata         (wdata),
      .pval          (val_r),
      .eff_k         (eff_k),
      .chain_in_idx  (ch_idx[i]),
      .chain_in_dist (ch_dist[i]),
      .chain_out_idx (ch_idx[i+1]),
      .chain_out_dist(ch_dist[i+1]),
      .rdata         (cell_rdata[i]),
      .count         (cell_count[i])
    );
  end

  okm_rate #(
    .COUNT_BITS(COUNT_BITS)
  ) u_rate (
    .clk  (clk),
    .rst  (rst),
    .start(rate_start),
    .cnt  (cnt_r),
    .done (rate_done),
    .rate (rate)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r  <= cmd;
            csel_r <= center_sel;
            dsel_r <= dim_sel;
            val_r  <= coord_value;
            last_r <= last_dim;
            state  <= S_DEC;
          end
        end
        S_DEC: begin
          unique case (cmd_r)
            okm_pkg::CMD_READ:  state <= S_RD;
            okm_pkg::CMD_POINT: begin
              if (pt_in) begin
                state <= S_P1;
              end else if (last_r) begin
                srch_cnt <= '0;
                state    <= S_SRCH;
              end else begin
                state <= S_IDLE;
              end
            end
            default: state <= S_IDLE;
          endcase
        end
        S_RD: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_P1: state <= S_P2;
        S_P2: state <= S_P3;
        S_P3: begin
          srch_cnt <= '0;
          state    <= last_r ? S_SRCH : S_IDLE;
        end
        S_SRCH: begin
          srch_cnt <= srch_cnt + 1'b1;
          if (srch_cnt == KW'(MAX_CENTERS - 1)) begin
            state <= S_WIN;
          end
        end
        S_WIN: begin
          win   <= ch_idx[MAX_CENTERS];
          bestd <= ch_dist[MAX_CENTERS];
          state <= S_INC;
        end
        S_INC: state <= S_CNT;
        S_CNT: begin
          cnt_r <= cell_count[win];
          state <= S_RSTART;
        end
        S_RSTART: begin
          upd_d <= '0;
          state <= S_RATE;
        end
        S_RATE: begin
          if (rate_done) begin
            state <= S_U0;
          end
        end
        S_U0: state <= S_U1;
        S_U1: begin
          cw_r    <= cell_rdata[win];
          delta_r <= $signed({pb_rdata[CWD-1], pb_rdata})
                   - $signed({cell_rdata[win][CWD-1], cell_rdata[win]});
          state   <= S_U2;
        end
        S_U2: begin
          prod_r <= PRW'(delta_r) * PRW'($signed({1'b0, rate}));
          state  <= S_U3;
        end
        S_U3: begin
          upd_d <= upd_d + 1'b1;
          state <= (upd_d == eff_d - 1'b1) ? S_OUT : S_U0;
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_RD && out_free) begin
      out_valid <= 1'b1;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RD && out_free) begin
      result_kind   <= okm_pkg::KIND_READ;
      winner        <= '0;
      best_distance <= '0;
      hit_count     <= '0;
      read_value    <= (csel_ok && dsel_ok) ? cell_rdata[CW'(csel_r)] : '0;
    end else if (state == S_OUT && out_free) begin
      result_kind   <= okm_pkg::KIND_POINT;
      winner        <= 5'(win);
      best_distance <= bestd;
      hit_count     <= cnt_r;
      read_value    <= '0;
    end
  end

  // checks
  a_win_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_INC |-> 32'(win) < 32'(eff_k))
    else $error("winner outside centers in use");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_RSTART |-> cnt_r != '0)
    else $error("zero hit count at rate start");

  a_rate_range: assert property (@(posedge clk) disable iff (rst)
    rate_done |-> (rate != '0) && (32'(rate) <= 32'd65536))
    else $error("learning rate out of range");

  a_dist_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_free) |=> ch_dist[0] == '1 && state == S_IDLE)
    else $error("point close did not return to idle");

endmodule

### bench/tb_top.sv
// Testbench for online_kmeans_update: directed and random beats checked
// against an in-bench k-means predictor. Depends on okm_pkg and the DUT.
`timescale 1ns / 1ps

module tb_top;

  localparam int NC = 32;
  localparam int ND = 64;
  localparam int CW = 20;
  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};
  localparam int RAND_BEATS = 530;

  typedef struct packed {
    logic              kind;
    logic [4:0]        win;
    logic [63:0]       bdist;
    logic [CW-1:0]     cnt;
    logic signed [31:0] rval;
  } okm_result_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic cfg_index = 0;
  logic [6:0] cfg_data = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] cmd = okm_pkg::CMD_NOP;
  logic [4:0] center_sel = 0;
  logic [5:0] dim_sel = 0;
  logic signed [31:0] coord_value = 0;
  logic last_dim = 0;
  logic out_valid;
  logic out_stall = 0;
  logic result_kind;
  logic [4:0] winner;
  logic [63:0] best_distance;
  logic [CW-1:0] hit_count;
  logic signed [31:0] read_value;

  online_kmeans_update dut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic signed [31:0] ctr_mem [NC][ND];
  logic [CW-1:0]      hits [NC];
  logic signed [31:0] pbuf [ND];
  logic [63:0]        pdist [NC];
  logic [5:0]         k_reg;
  logic [6:0]         d_reg;

  okm_result_t pending_results [$];
  int  errors = 0;
  int  idle_cycles = 0;
  bit  rx_hold = 0;
  bit  rx_stall_en = 1;
  bit  tx_gap_en = 1;

  function automatic int eff_k();
    if (k_reg == 0) return 1;
    return (k_reg > NC) ? NC : k_reg;
  endfunction

  function automatic int eff_d();
    if (d_reg == 0) return 1;
    return (d_reg > ND) ? ND : d_reg;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // update predictor with one beat, queue its result if any
  task automatic predict_beat(logic [1:0] c, logic [4:0] cs, logic [5:0] ds,
                              logic signed [31:0] v, logic lst);
    okm_result_t r;
    longint delta, cv, stp;
    logic [63:0] sq, s, bestd, rate;
    int best, nd;
    r = '0;
    nd = eff_d();
    case (c)
      okm_pkg::CMD_WRITE: begin
        ctr_mem[cs][ds] = v;
        if (ds == 0) hits[cs] = 0;
      end
      okm_pkg::CMD_READ: begin
        r.kind = okm_pkg::KIND_READ;
        r.rval = ctr_mem[cs][ds];
        pending_results.push_back(r);
      end
      okm_pkg::CMD_POINT: begin
        if (ds < nd) begin
          pbuf[ds] = v;
          for (int i = 0; i < eff_k(); i++) begin
            delta = longint'(v) - longint'(ctr_mem[i][ds]);
            if (delta < 0) delta = -delta;
            sq = delta * delta;
            s = pdist[i] + sq;
            pdist[i] = (s < sq) ? 64'hFFFF_FFFF_FFFF_FFFF : s;
          end
        end
        if (lst) begin
          best = 0;
          bestd = pdist[0];
          for (int i = 1; i < eff_k(); i++)
            if (pdist[i] < bestd) begin
              bestd = pdist[i];
              best = i;
            end
          if (hits[best] != CNT_MAX) hits[best]++;
          rate = int_sqrt((64'd1 << 32) / hits[best]);
          for (int d = 0; d < nd; d++) begin
            cv = ctr_mem[best][d];
            delta = longint'(pbuf[d]) - cv;
            stp = (delta * longint'(rate)) >>> 16;
            ctr_mem[best][d] = 32'(cv + stp);
          end
          for (int i = 0; i < NC; i++) pdist[i] = 0;
          r.kind = okm_pkg::KIND_POINT;
          r.win = 5'(best);
          r.bdist = bestd;
          r.cnt = hits[best];
          pending_results.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  // send one beat and wait for acceptance; valid then drops after the beat,
  // while the block is busy with the beat anyway
  task automatic send_beat(logic [1:0] c, logic [4:0] cs, logic [5:0] ds,
                           logic signed [31:0] v, logic lst);
    if (tx_gap_en && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 3))
        @(posedge clk);
    in_valid <= 1;
    cmd <= c;
    center_sel <= cs;
    dim_sel <= ds;
    coord_value <= v;
    last_dim <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_beat(c, cs, ds, v, lst);
    in_valid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (5 + NC + 5 + 35 + 4 * ND + 10) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [6:0] val);
    drain();
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == okm_pkg::REG_CLUSTER_COUNT) k_reg = val[5:0];
    else d_reg = val;
  endtask

  // load every center in use, all dims in use, with random values
  task automatic load_centers(int spread);
    for (int c = 0; c < eff_k(); c++)
      for (int d = 0; d < eff_d(); d++)
        send_beat(okm_pkg::CMD_WRITE, 5'(c), 6'(d),
                  32'($signed($urandom_range(0, 2 * spread)) - spread), 1'b0);
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom();
      default: return $signed($urandom_range(0, 20'hFFFFF)) - 32'sh80000;
    endcase
  endfunction

  // one point in order over dims in use
  task automatic send_point();
    int nd;
    nd = eff_d();
    for (int d = 0; d < nd; d++)
      send_beat(okm_pkg::CMD_POINT, 5'($urandom()), 6'(d), rand_coord(), d == nd - 1);
  endtask

  task automatic test_directed();
    write_reg(okm_pkg::REG_CLUSTER_COUNT, 7'd3);
    write_reg(okm_pkg::REG_DIM_COUNT, 7'd2);
    load_centers(1000);
    // extremes and tie between equal centers
    send_beat(okm_pkg::CMD_WRITE, 1, 0, 32'sh0, 0);
    send_beat(okm_pkg::CMD_WRITE, 1, 1, 32'sh0, 0);
    send_beat(okm_pkg::CMD_WRITE, 2, 0, 32'sh0, 0);
    send_beat(okm_pkg::CMD_WRITE, 2, 1, 32'sh0, 0);
    send_beat(okm_pkg::CMD_POINT, 0, 0, 32'h7FFF_FFFF, 0);
    send_beat(okm_pkg::CMD_POINT, 31, 1, 32'h8000_0000, 1);
    // repeated coordinate, skipped coordinate, beyond dim_count closing point
    send_beat(okm_pkg::CMD_POINT, 0, 0, 32'sd5, 0);
    send_beat(okm_pkg::CMD_POINT, 0, 0, 32'sd7, 0);
    send_beat(okm_pkg::CMD_POINT, 0, 63, 32'sd9, 1);
    send_beat(okm_pkg::CMD_POINT, 0, 1, -32'sd4, 1);
    send_beat(okm_pkg::CMD_NOP, 31, 63, 32'hFFFF_FFFF, 1);
    send_beat(okm_pkg::CMD_WRITE, 31, 63, 32'h8000_0000, 1);
    send_beat(okm_pkg::CMD_READ, 31, 63, 0, 1);
    send_beat(okm_pkg::CMD_READ, 0, 1, 0, 0);
    send_beat(okm_pkg::CMD_READ, 2, 0, 0, 0);
  endtask

  // saturate a distance: huge deltas across all 64 dims
  task automatic test_dist_saturation();
    write_reg(okm_pkg::REG_CLUSTER_COUNT, 7'd1);
    write_reg(okm_pkg::REG_DIM_COUNT, 7'd64);
    for (int d = 0; d < ND; d++)
      send_beat(okm_pkg::CMD_WRITE, 0, 6'(d), 32'h8000_0000, 0);
    for (int d = 0; d < ND; d++)
      send_beat(okm_pkg::CMD_POINT, 0, 6'(d), 32'h7FFF_FFFF, d == ND - 1);
  endtask

  // out-of-range register values: 0 acts as 1, above max acts as max
  task automatic test_reg_extremes();
    write_reg(okm_pkg::REG_CLUSTER_COUNT, 7'd0);
    write_reg(okm_pkg::REG_DIM_COUNT, 7'd0);
    load_centers(100000);
    repeat (3) send_point();
    // cluster count above the maximum
    write_reg(okm_pkg::REG_CLUSTER_COUNT, 7'd63);
    write_reg(okm_pkg::REG_DIM_COUNT, 7'd3);
    load_centers(1 << 20);
    repeat (2) send_point();
    // dim count above the maximum
    write_reg(okm_pkg::REG_CLUSTER_COUNT, 7'd1);
    write_reg(okm_pkg::REG_DIM_COUNT, 7'd127);
    load_centers(1 << 20);
    send_point();
    write_reg(okm_pkg::REG_CLUSTER_COUNT, 7'd32);
    write_reg(okm_pkg::REG_DIM_COUNT, 7'd2);
    send_point();
  endtask

  // long receiver hold-off while the sender keeps offering beats
  task automatic test_backpressure();
    write_reg(okm_pkg::REG_CLUSTER_COUNT, 7'd4);
    write_reg(okm_pkg::REG_DIM_COUNT, 7'd3);
    load_centers(50000);
    rx_hold = 1;
    fork
      begin
        repeat (400) @(posedge clk);
        rx_hold = 0;
      end
      begin
        for (int i = 0; i < 12; i++)
          send_beat(okm_pkg::CMD_READ, 5'($urandom_range(0, 3)),
                    6'($urandom_range(0, 2)), 0, 0);
        repeat (3) send_point();
      end
    join
    // sender pauses until everything is back
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_random();
    int beats, kk, dd, p;
    beats = 0;
    while (beats < RAND_BEATS) begin
      kk = $urandom_range(0, 3) == 0 ? $urandom_range(1, 32) : $urandom_range(1, 6);
      dd = $urandom_range(0, 4) == 0 ? $urandom_range(1, 64) : $urandom_range(1, 5);
      // keep the center load short
      if (kk * dd > 192) dd = 192 / kk;
      write_reg(okm_pkg::REG_CLUSTER_COUNT, 7'(kk));
      write_reg(okm_pkg::REG_DIM_COUNT, 7'(dd));
      tx_gap_en = $urandom_range(0, 3) != 0;
      rx_stall_en = $urandom_range(0, 3) != 0;
      load_centers($urandom_range(0, 1) ? 1 << 18 : 1 << 30);
      beats += kk * dd;
      for (int n = 0; n < 25 && beats < RAND_BEATS; n++) begin
        p = $urandom_range(0, 9);
        if (p < 6) begin
          send_point();
          beats += dd;
        end else if (p < 8) begin
          send_beat(okm_pkg::CMD_READ, 5'($urandom_range(0, kk - 1)),
                    6'($urandom_range(0, dd - 1)), 0, 0);
          beats++;
        end else if (p == 8) begin
          // write in range; dim 0 clears the count
          send_beat(okm_pkg::CMD_WRITE, 5'($urandom_range(0, kk - 1)),
                    6'($urandom_range(0, dd - 1)), rand_coord(), 1'($urandom()));
          beats++;
        end else begin
          // noise: partial point with random dims, or a nop
          if ($urandom_range(0, 1))
            send_beat(okm_pkg::CMD_NOP, 5'($urandom()), 6'($urandom()),
                      32'($urandom()), 1'($urandom()));
          else
            send_beat(okm_pkg::CMD_POINT, 5'($urandom()), 6'($urandom_range(0, 63)),
                      rand_coord(), 0);
          beats++;
        end
      end
      send_beat(okm_pkg::CMD_POINT, 0, 63, 0, 1);
    end
    tx_gap_en = 1;
    rx_stall_en = 1;
  endtask

  // receiver stall generator
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      if (rx_hold) begin
        out_stall <= 1;
        @(posedge clk);
      end else if (rx_stall_en && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(0, 9) == 0 ? $urandom_range(10, 50) : $urandom_range(1, 3);
        out_stall <= 1;
        repeat (gap) @(posedge clk);
      end else begin
        out_stall <= 0;
        @(posedge clk);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    okm_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result kind=%0d", $time, result_kind);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (result_kind !== e.kind) begin
          $display("%0t kind exp %0d got %0d", $time, e.kind, result_kind);
          errors++;
        end
        if (winner !== e.win) begin
          $display("%0t winner exp %0d got %0d", $time, e.win, winner);
          errors++;
        end
        if (best_distance !== e.bdist) begin
          $display("%0t distance exp %h got %h", $time, e.bdist, best_distance);
          errors++;
        end
        if (hit_count !== e.cnt) begin
          $display("%0t count exp %0d got %0d", $time, e.cnt, hit_count);
          errors++;
        end
        if (read_value !== e.rval) begin
          $display("%0t read exp %h got %h", $time, e.rval, read_value);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat or taken result
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    for (int c = 0; c < NC; c++) begin
      hits[c] = 0;
      pdist[c] = 0;
      for (int d = 0; d < ND; d++) ctr_mem[c][d] = 0;
    end
    for (int d = 0; d < ND; d++) pbuf[d] = 0;
    k_reg = 1;
    d_reg = 1;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_dist_saturation();
    test_reg_extremes();
    test_backpressure();
    test_random();
    drain();
    if (errors == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
src/okm_pkg.sv
src/okm_ram.sv
src/okm_cell.sv
src/okm_rate.sv
src/online_kmeans_update.sv
bench/tb_top.sv
